/* rtl/core/rc4_pkg.sv */
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared types and constants for the RC4 keystream cipher.
// ----------------------------------------------------------------------------
package rc4_pkg;

  localparam int BYTE_W     = 8;
  localparam int SBOX_DEPTH = 256;
  localparam int SBOX_AW    = 8;

  // Byte address of the key register on the configuration port
  localparam logic [3:0] REG_KEY_ADDR = 4'h0;

  // One access to the permutation memory: one write and one read per cycle
  typedef struct packed {
    logic               we;
    logic [SBOX_AW-1:0] waddr;
    logic [BYTE_W-1:0]  wdata;
    logic [SBOX_AW-1:0] raddr;
  } sbox_req_t;

endpackage

/* rtl/core/rc4_keystream_cipher.sv */
// ----------------------------------------------------------------------------
// rc4_keystream_cipher
// RC4 stream cipher: each input byte is XORed with the next keystream byte.
// ----------------------------------------------------------------------------
// Usage:
//   The key lives in one 64-bit register at byte address 0 of the APB-style
//   configuration port; key byte n sits in bits 8n+7..8n and the low
//   KEY_BYTES bytes are used. A key write takes effect at the next key
//   schedule.
//   Input words carry a data byte in in_tdata and a restart flag in in_tuser.
//   The first word after reset, and any word with restart set, first refills
//   the permutation memory (state INIT) and runs the key schedule (states
//   KS_A, KS_B, KS_C and KS_D for each step), then clears both indices.
//   A byte then passes through states P1 to P5, using the shared adder and
//   the memory ports, after the idle state in which it is accepted; a new
//   word is accepted only once the last one has left state P5.
//   The result appears in the output register the cycle after the last step.
//   in_tready is high only while the sequencer is idle. A stalled result
//   waits in the output register while the next word is accepted and
//   processed; the sequencer holds at its last step until the register frees.
//   Reset clears the indices, the handshake state and the key.
// ----------------------------------------------------------------------------
module rc4_keystream_cipher #(
  parameter int KEY_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] restart
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [7:0] out_byte
);
  import rc4_pkg::*;

  logic [63:0]       key_r;
  logic              key_wr;
  sbox_req_t         sbox_req;
  logic [BYTE_W-1:0] sbox_rdata;

  assign cfg_pready = 1'b1;
  assign key_wr     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr == REG_KEY_ADDR);
  assign cfg_prdata = (cfg_paddr == REG_KEY_ADDR) ? key_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (key_wr) begin
      key_r <= cfg_pwdata;
    end
  end

  rc4_ctrl #(
    .KEY_BYTES (KEY_BYTES)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .key        (key_r[KEY_BYTES*8-1:0]),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_data    (in_tdata),
    .in_restart (in_tuser),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_tdata),
    .sbox_req   (sbox_req),
    .sbox_rdata (sbox_rdata)
  );

  rc4_sbox u_sbox (
    .clk   (clk),
    .req   (sbox_req),
    .rdata (sbox_rdata)
  );

endmodule

/* rtl/core/rc4_sbox.sv */
// ----------------------------------------------------------------------------
// rc4_sbox
// 256 x 8 permutation memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module rc4_sbox (
  input  logic                              clk,
  input  rc4_pkg::sbox_req_t                req,
  output logic [rc4_pkg::BYTE_W-1:0]        rdata
);
  import rc4_pkg::*;

  logic [BYTE_W-1:0] mem [SBOX_DEPTH];
  logic [BYTE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // read returns the contents before a write in the same cycle
  always_ff @(posedge clk) begin
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/rc4_ctrl.sv */
// ----------------------------------------------------------------------------
// rc4_ctrl
// Sequencer for table fill, key schedule and keystream generation, built
// around one shared three-input byte adder. Holds the output word register.
// ----------------------------------------------------------------------------
module rc4_ctrl #(
  parameter int KEY_BYTES = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [KEY_BYTES*8-1:0]            key,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [rc4_pkg::BYTE_W-1:0]        in_data,
  input  logic                              in_restart,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rc4_pkg::BYTE_W-1:0]        out_data,
  output rc4_pkg::sbox_req_t                sbox_req,
  input  logic [rc4_pkg::BYTE_W-1:0]        sbox_rdata
);
  import rc4_pkg::*;

  localparam int KIDX_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam logic [KIDX_W-1:0] KIDX_LAST = KIDX_W'(KEY_BYTES - 1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_INIT = 4'd1;
  localparam logic [3:0] ST_KS_A = 4'd2;
  localparam logic [3:0] ST_KS_B = 4'd3;
  localparam logic [3:0] ST_KS_C = 4'd4;
  localparam logic [3:0] ST_KS_D = 4'd5;
  localparam logic [3:0] ST_P1   = 4'd6;
  localparam logic [3:0] ST_P2   = 4'd7;
  localparam logic [3:0] ST_P3   = 4'd8;
  localparam logic [3:0] ST_P4   = 4'd9;
  localparam logic [3:0] ST_P5   = 4'd10;

  localparam logic [BYTE_W-1:0] LAST_IDX = BYTE_W'(SBOX_DEPTH - 1);

  logic [3:0]        state_r, state_nxt;
  logic              ready_tbl_r, ready_tbl_nxt;
  logic [BYTE_W-1:0] m_r, m_nxt;
  logic [BYTE_W-1:0] i_r, i_nxt;
  logic [BYTE_W-1:0] j_r, j_nxt;
  logic [BYTE_W-1:0] sm_r, sm_nxt;
  logic [BYTE_W-1:0] sj_r, sj_nxt;
  logic [BYTE_W-1:0] kaddr_r, kaddr_nxt;
  logic [BYTE_W-1:0] data_r, data_nxt;
  logic [KIDX_W-1:0] kidx_r, kidx_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_data_r, out_data_nxt;

  logic [BYTE_W-1:0] add_a, add_b, add_c, add_y;
  logic [BYTE_W-1:0] key_byte;
  logic [BYTE_W-1:0] ks_byte;

  // shared byte adder, all sums mod 256
  assign add_y    = add_a + add_b + add_c;
  assign key_byte = key[kidx_r*8 +: 8];
  // forward the byte written in state P4 when the read hits its address
  assign ks_byte  = (kaddr_r == j_r) ? sm_r : sbox_rdata;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    ready_tbl_nxt = ready_tbl_r;
    m_nxt         = m_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    sm_nxt        = sm_r;
    sj_nxt        = sj_r;
    kaddr_nxt     = kaddr_r;
    data_nxt      = data_r;
    kidx_nxt      = kidx_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    add_a         = '0;
    add_b         = '0;
    add_c         = '0;
    sbox_req      = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          data_nxt = in_data;
          if (in_restart || !ready_tbl_r) begin
            m_nxt     = '0;
            state_nxt = ST_INIT;
          end else begin
            state_nxt = ST_P1;
          end
        end
      end
      ST_INIT: begin
        sbox_req.we    = 1'b1;
        sbox_req.waddr = m_r;
        sbox_req.wdata = m_r;
        add_a          = m_r;
        add_c          = 8'd1;
        m_nxt          = add_y;
        if (m_r == LAST_IDX) begin
          j_nxt     = '0;
          kidx_nxt  = '0;
          state_nxt = ST_KS_A;
        end
      end
      ST_KS_A: begin
        sbox_req.raddr = m_r;
        state_nxt      = ST_KS_B;
      end
      ST_KS_B: begin
        add_a          = j_r;
        add_b          = sbox_rdata;
        add_c          = key_byte;
        j_nxt          = add_y;
        sm_nxt         = sbox_rdata;
        sbox_req.raddr = add_y;
        state_nxt      = ST_KS_C;
      end
      ST_KS_C: begin
        sbox_req.we    = 1'b1;
        sbox_req.waddr = m_r;
        sbox_req.wdata = sbox_rdata;
        state_nxt      = ST_KS_D;
      end
      ST_KS_D: begin
        sbox_req.we    = 1'b1;
        sbox_req.waddr = j_r;
        sbox_req.wdata = sm_r;
        add_a          = m_r;
        add_c          = 8'd1;
        m_nxt          = add_y;
        kidx_nxt       = (kidx_r == KIDX_LAST) ? '0 : kidx_r + 1'b1;
        if (m_r == LAST_IDX) begin
          i_nxt         = '0;
          j_nxt         = '0;
          ready_tbl_nxt = 1'b1;
          state_nxt     = ST_P1;
        end else begin
          state_nxt = ST_KS_A;
        end
      end
      ST_P1: begin
        add_a          = i_r;
        add_c          = 8'd1;
        i_nxt          = add_y;
        sbox_req.raddr = add_y;
        state_nxt      = ST_P2;
      end
      ST_P2: begin
        add_a          = j_r;
        add_b          = sbox_rdata;
        j_nxt          = add_y;
        sm_nxt         = sbox_rdata;
        sbox_req.raddr = add_y;
        state_nxt      = ST_P3;
      end
      ST_P3: begin
        sbox_req.we    = 1'b1;
        sbox_req.waddr = i_r;
        sbox_req.wdata = sbox_rdata;
        sj_nxt         = sbox_rdata;
        state_nxt      = ST_P4;
      end
      ST_P4: begin
        sbox_req.we    = 1'b1;
        sbox_req.waddr = j_r;
        sbox_req.wdata = sm_r;
        add_a          = sm_r;
        add_b          = sj_r;
        kaddr_nxt      = add_y;
        sbox_req.raddr = add_y;
        state_nxt      = ST_P5;
      end
      ST_P5: begin
        // hold the read address so the data stays put while stalled
        sbox_req.raddr = kaddr_r;
        if (!out_valid_r || out_ready) begin
          out_data_nxt  = data_r ^ ks_byte;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ready_tbl_r <= 1'b0;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      ready_tbl_r <= ready_tbl_nxt;
      out_valid_r <= out_valid_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r        <= m_nxt;
    sm_r       <= sm_nxt;
    sj_r       <= sj_nxt;
    kaddr_r    <= kaddr_nxt;
    data_r     <= data_nxt;
    kidx_r     <= kidx_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
